// File: rtl/imu_deadband_dead_reckoning_unit_assert.svh
// Assertion macros for the dead-reckoning unit checkers.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef IMU_DEADBAND_DEAD_RECKONING_UNIT_ASSERT_SVH
`define IMU_DEADBAND_DEAD_RECKONING_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IDR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("idr assertion failed");

// Next-cycle implication.
`define IDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("idr assertion failed");

`endif

// File: rtl/idr_pkg.sv
// Shared widths, codes and controller/datapath interface types
// for the dead-reckoning unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package idr_pkg;

  localparam int VEL_WIDTH  = 48;
  localparam int POS_WIDTH  = 64;
  localparam int ACC_IN_W   = 16;
  localparam int DT_W       = 16;
  localparam int THR_W      = 15;
  localparam int INTV_W     = 16;
  localparam int SINCE_W    = 17;
  localparam int OUT_W      = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;

  // velocity is multiplied by dt in two halves on the shared multiplier
  localparam int VEL_LO  = VEL_WIDTH / 2;
  localparam int VEL_HI  = VEL_WIDTH - VEL_LO;
  localparam int MUL_AW  = VEL_HI + 1;
  localparam int MUL_PW  = MUL_AW + DT_W + 1;
  localparam int APROD_W = ACC_IN_W + DT_W + 1;
  localparam int SUMV_W  = VEL_WIDTH + 2;
  localparam int ACC_W   = ((POS_WIDTH > VEL_WIDTH + DT_W + 1) ?
                            POS_WIDTH : VEL_WIDTH + DT_W + 1) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

  localparam logic [THR_W-1:0]  THR_RESET  = 15'd10;
  localparam logic [INTV_W-1:0] INTV_RESET = 16'd100;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ACC,
    OP_VEL,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_POS,
    OP_TIME,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic report;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/idr_ctrl.sv
// Sequencer for the dead-reckoning unit: steps each axis through the
// shared-multiplier schedule and owns the handshakes. Uses idr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire idr_pkg::status_t status,
  output idr_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_VEL,
    S_MUL_LO,
    S_MUL_HI,
    S_POS,
    S_TIME,
    S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [idr_pkg::AXIS_W-1:0]   axis_r, axis_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = idr_pkg::OP_NONE;
    cmd.axis      = axis_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op   = idr_pkg::OP_LOAD;
          axis_nxt = '0;
          if (!status.dt_zero) begin
            state_nxt = S_MUL_A;
          end
        end
      end
      S_MUL_A: begin
        cmd.op    = idr_pkg::OP_MUL_ACC;
        state_nxt = S_VEL;
      end
      S_VEL: begin
        cmd.op    = idr_pkg::OP_VEL;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op    = idr_pkg::OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op    = idr_pkg::OP_MUL_HI;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.op = idr_pkg::OP_POS;
        if (axis_r == idr_pkg::LAST_AXIS) begin
          state_nxt = S_TIME;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MUL_A;
        end
      end
      S_TIME: begin
        cmd.op    = idr_pkg::OP_TIME;
        state_nxt = status.report ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        // hold the report until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = idr_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/idr_datapath.sv
// Datapath for the dead-reckoning unit: config registers, deadband, shared
// multiplier, saturating velocity/position state and report timer. Uses idr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_write_en,
  input  wire logic [idr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [idr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_x,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_y,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_z,
  input  wire logic [idr_pkg::DT_W-1:0]          in_elapsed_ms,
  output logic signed [idr_pkg::OUT_W-1:0]       out_pos_x,
  output logic signed [idr_pkg::OUT_W-1:0]       out_pos_y,
  output logic signed [idr_pkg::OUT_W-1:0]       out_pos_z,
  input  wire idr_pkg::cmd_t                     cmd,
  output idr_pkg::status_t                       status
);

  localparam int VEL_WIDTH = idr_pkg::VEL_WIDTH;
  localparam int POS_WIDTH = idr_pkg::POS_WIDTH;
  localparam int ACC_IN_W  = idr_pkg::ACC_IN_W;
  localparam int DT_W      = idr_pkg::DT_W;
  localparam int THR_W     = idr_pkg::THR_W;
  localparam int SINCE_W   = idr_pkg::SINCE_W;
  localparam int OUT_W     = idr_pkg::OUT_W;
  localparam int VEL_LO    = idr_pkg::VEL_LO;
  localparam int MUL_AW    = idr_pkg::MUL_AW;
  localparam int MUL_PW    = idr_pkg::MUL_PW;
  localparam int APROD_W   = idr_pkg::APROD_W;
  localparam int SUMV_W    = idr_pkg::SUMV_W;
  localparam int ACC_W     = idr_pkg::ACC_W;
  localparam int NUM_AXES  = idr_pkg::NUM_AXES;

  logic [THR_W-1:0]              thr_r;
  logic [idr_pkg::INTV_W-1:0]    intv_r;
  logic [SINCE_W-1:0]            since_r, since_sum;
  logic signed [VEL_WIDTH-1:0]   vel_r [NUM_AXES];
  logic signed [POS_WIDTH-1:0]   pos_r [NUM_AXES];

  logic signed [ACC_IN_W-1:0]    accel_r [NUM_AXES];
  logic [DT_W-1:0]               dt_r;
  logic signed [MUL_PW-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;

  logic signed [ACC_IN_W-1:0]    a_sel, a_db;
  logic [ACC_IN_W:0]             a_mag;
  logic signed [VEL_WIDTH-1:0]   vel_sel, vel_sat;
  logic signed [POS_WIDTH-1:0]   pos_sel, pos_sat;
  logic signed [MUL_AW-1:0]      mul_a;
  logic signed [DT_W:0]          mul_b;
  logic signed [MUL_PW-1:0]      mul_p;
  logic signed [APROD_W-1:0]     a_prod;
  logic signed [SUMV_W-1:0]      v_sum;
  logic signed [ACC_W-1:0]       p_sum;

  assign a_sel   = accel_r[cmd.axis];
  assign vel_sel = vel_r[cmd.axis];
  assign pos_sel = pos_r[cmd.axis];

  // deadband: magnitude of the most negative code is 2^15
  assign a_mag = a_sel[ACC_IN_W-1] ? ((ACC_IN_W + 1)'(0) - {a_sel[ACC_IN_W-1], a_sel})
                                   : {1'b0, a_sel};
  assign a_db  = (a_mag < (ACC_IN_W + 1)'(thr_r)) ? '0 : a_sel;

  always_comb begin
    case (cmd.op)
      idr_pkg::OP_MUL_ACC: mul_a = MUL_AW'(a_db);
      idr_pkg::OP_MUL_LO:  mul_a = MUL_AW'(vel_sel[VEL_LO-1:0]);
      idr_pkg::OP_MUL_HI:  mul_a = MUL_AW'(signed'(vel_sel[VEL_WIDTH-1:VEL_LO]));
      default:             mul_a = '0;
    endcase
  end

  assign mul_b = {1'b0, dt_r};
  assign mul_p = mul_a * mul_b;

  // velocity update, saturating
  assign a_prod = prod_r[APROD_W-1:0];
  assign v_sum  = SUMV_W'(vel_sel) + SUMV_W'(a_prod);

  always_comb begin
    if (v_sum[SUMV_W-1:VEL_WIDTH-1] == '0 || v_sum[SUMV_W-1:VEL_WIDTH-1] == '1) begin
      vel_sat = v_sum[VEL_WIDTH-1:0];
    end else if (v_sum[SUMV_W-1]) begin
      vel_sat = {1'b1, {(VEL_WIDTH - 1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(VEL_WIDTH - 1){1'b1}}};
    end
  end

  // position update: low half already folded into acc_r, add high half
  assign acc_nxt = ACC_W'(pos_sel) + ACC_W'(prod_r[VEL_LO+DT_W-1:0]);
  assign p_sum   = acc_r + (ACC_W'(prod_r) <<< VEL_LO);

  always_comb begin
    if (p_sum[ACC_W-1:POS_WIDTH-1] == '0 || p_sum[ACC_W-1:POS_WIDTH-1] == '1) begin
      pos_sat = p_sum[POS_WIDTH-1:0];
    end else if (p_sum[ACC_W-1]) begin
      pos_sat = {1'b1, {(POS_WIDTH - 1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_WIDTH - 1){1'b1}}};
    end
  end

  assign since_sum      = since_r + SINCE_W'(dt_r);
  assign status.report  = (since_sum >= SINCE_W'(intv_r));
  assign status.dt_zero = (in_elapsed_ms == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= idr_pkg::THR_RESET;
      intv_r  <= idr_pkg::INTV_RESET;
      since_r <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          idr_pkg::CFG_DEADBAND: thr_r  <= cfg_data[THR_W-1:0];
          idr_pkg::CFG_INTERVAL: intv_r <= cfg_data;
          default: begin
          end
        endcase
      end
      case (cmd.op)
        idr_pkg::OP_VEL:  vel_r[cmd.axis] <= vel_sat;
        idr_pkg::OP_POS:  pos_r[cmd.axis] <= pos_sat;
        idr_pkg::OP_TIME: since_r <= status.report ? '0 : since_sum;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      idr_pkg::OP_LOAD: begin
        accel_r[0] <= in_accel_x;
        accel_r[1] <= in_accel_y;
        accel_r[2] <= in_accel_z;
        dt_r       <= in_elapsed_ms;
      end
      idr_pkg::OP_MUL_ACC, idr_pkg::OP_MUL_LO: begin
        prod_r <= mul_p;
      end
      idr_pkg::OP_MUL_HI: begin
        prod_r <= mul_p;
        acc_r  <= acc_nxt;
      end
      idr_pkg::OP_OUT: begin
        out_pos_x <= OUT_W'(pos_r[0]);
        out_pos_y <= OUT_W'(pos_r[1]);
        out_pos_z <= OUT_W'(pos_r[2]);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/imu_deadband_dead_reckoning_unit.sv
// Top level of the dead-reckoning unit: joins the sequencer and datapath.
// Depends on idr_pkg, idr_ctrl and idr_datapath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   input    | in_valid / in_ready   | in_accel_x/y/z, in_elapsed_ms
//   result   | out_valid / out_ready | out_pos_x/y/z
//   config   | cfg_write_en          | cfg_index, cfg_data
//
// A request with nonzero elapsed time holds in_ready low while it steps each
// axis in turn through the one shared multiplier (accel*dt, then low and
// high halves of velocity*dt), then updates the timer and any report.
// A request with zero elapsed time is taken and dropped; in_ready stays high.
// Reset is synchronous; state clears at once, with no clearing pass.
// A report waits while the output register still holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none
module imu_deadband_dead_reckoning_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_write_en,
  input  wire logic [idr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [idr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_x,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_y,
  input  wire logic signed [idr_pkg::ACC_IN_W-1:0] in_accel_z,
  input  wire logic [idr_pkg::DT_W-1:0]            in_elapsed_ms,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [idr_pkg::OUT_W-1:0]         out_pos_x,
  output logic signed [idr_pkg::OUT_W-1:0]         out_pos_y,
  output logic signed [idr_pkg::OUT_W-1:0]         out_pos_z
);

  idr_pkg::cmd_t    cmd;
  idr_pkg::status_t status;

  idr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  idr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_elapsed_ms (in_elapsed_ms),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
`default_nettype wire

// File: rtl/idr_checker.sv
// Port-level checks for the dead-reckoning unit, bound to the top level.
// Depends on idr_pkg and imu_deadband_dead_reckoning_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_deadband_dead_reckoning_unit_assert.svh"
module idr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [idr_pkg::DT_W-1:0]       in_elapsed_ms,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [idr_pkg::OUT_W-1:0]      out_pos_x,
  input wire logic [idr_pkg::OUT_W-1:0]      out_pos_y,
  input wire logic [idr_pkg::OUT_W-1:0]      out_pos_z
);

  `IDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IDR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z))
  `IDR_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && in_elapsed_ms != '0, !in_ready)
  `IDR_ASSERT_NEXT(a_skip_zero_dt, in_valid && in_ready && in_elapsed_ms == '0, in_ready && !$rose(out_valid))

endmodule

bind imu_deadband_dead_reckoning_unit idr_checker u_idr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_elapsed_ms (in_elapsed_ms),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_pos_y     (out_pos_y),
  .out_pos_z     (out_pos_z)
);
`default_nettype wire
